FILE: rtl/core/pdc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the pd controller with output clamp
// no dependencies; used by the channel interfaces and every rtl module
package pdc_pkg;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PROP_GAIN  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_OUT_UPPER  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_OUT_LOWER  = 3'd4;

  // gain digit handled per multiplier step
  localparam int DIGIT_BITS = 16;

  // saturation point of a gain term magnitude
  localparam int TERM_LIM_BIT = 61;

  typedef struct packed {
    logic load_in;
    logic calc_err;
    logic mul_init;
    logic mul_sel_d;
    logic mul_step;
    logic term_p;
    logic term_d;
    logic div_init;
    logic div_step;
    logic deriv_fin;
    logic sum;
    logic out_load;
    logic out_zero;
  } pdc_cmd_t;

  typedef struct packed {
    logic dt_zero;
    logic mul_last;
    logic div_last;
    logic out_free;
  } pdc_stat_t;

endpackage

FILE: rtl/core/pdc_ifs.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces: input items, results and register writes
// depends on pdc_pkg
interface pdc_in_if #(parameter int DATA_WIDTH = 32) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] setpoint;
  logic signed [DATA_WIDTH-1:0] measured;
  logic        [DATA_WIDTH-1:0] step_time;

  modport source (output valid, setpoint, measured, step_time, input ready);
  modport sink   (input valid, setpoint, measured, step_time, output ready);
endinterface

interface pdc_out_if #(parameter int DATA_WIDTH = 32) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] drive;
  logic signed [DATA_WIDTH-1:0] error_now;
  logic                         clamped;

  modport source (output valid, drive, error_now, clamped, input ready);
  modport sink   (input valid, drive, error_now, clamped, output ready);
endinterface

interface pdc_cfg_if #(parameter int DATA_WIDTH = 32) ();
  logic                               valid;
  logic                               ready;
  logic [pdc_pkg::CFG_IDX_BITS-1:0]   index;
  logic [DATA_WIDTH-1:0]              data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/pdc_regs.sv
`timescale 1ns / 1ps
// configuration registers: enable, gains and output limits
// depends on pdc_pkg and pdc_cfg_if
module pdc_regs #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  pdc_cfg_if.sink                      cfg,
  output logic                         enable,
  output logic signed [DATA_WIDTH-1:0] prop_gain,
  output logic signed [DATA_WIDTH-1:0] deriv_gain,
  output logic signed [DATA_WIDTH-1:0] out_upper,
  output logic signed [DATA_WIDTH-1:0] out_lower
);
  import pdc_pkg::*;

  localparam logic [DATA_WIDTH-1:0] ONE_FX = {{(DATA_WIDTH-1){1'b0}}, 1'b1} << FRAC_BITS;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b0;
      prop_gain  <= '0;
      deriv_gain <= '0;
      out_upper  <= ONE_FX;
      out_lower  <= -ONE_FX;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ENABLE:     enable     <= cfg.data[0];
        REG_PROP_GAIN:  prop_gain  <= cfg.data;
        REG_DERIV_GAIN: deriv_gain <= cfg.data;
        REG_OUT_UPPER:  out_upper  <= cfg.data;
        REG_OUT_LOWER:  out_lower  <= cfg.data;
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/pdc_ctrl.sv
`timescale 1ns / 1ps
// sequencer of the pd controller: steps the datapath through one item
// depends on pdc_pkg
module pdc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                enable,
  input  pdc_pkg::pdc_stat_t  stat,
  output pdc_pkg::pdc_cmd_t   cmd
);
  import pdc_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ZERO    = 4'd1;
  localparam logic [3:0] S_ERR     = 4'd2;
  localparam logic [3:0] S_MP_INIT = 4'd3;
  localparam logic [3:0] S_MP_RUN  = 4'd4;
  localparam logic [3:0] S_TERM_P  = 4'd5;
  localparam logic [3:0] S_DIV_RUN = 4'd6;
  localparam logic [3:0] S_DERIV   = 4'd7;
  localparam logic [3:0] S_MD_INIT = 4'd8;
  localparam logic [3:0] S_MD_RUN  = 4'd9;
  localparam logic [3:0] S_TERM_D  = 4'd10;
  localparam logic [3:0] S_SUM     = 4'd11;
  localparam logic [3:0] S_OUT     = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = enable ? S_ERR : S_ZERO;
        end
      end
      S_ZERO: begin
        if (stat.out_free) begin
          cmd.out_zero = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_ERR: begin
        cmd.calc_err = 1'b1;
        state_next   = S_MP_INIT;
      end
      S_MP_INIT: begin
        cmd.mul_init = 1'b1;
        state_next   = S_MP_RUN;
      end
      S_MP_RUN: begin
        cmd.mul_step = 1'b1;
        if (stat.mul_last) begin
          state_next = S_TERM_P;
        end
      end
      S_TERM_P: begin
        cmd.term_p   = 1'b1;
        cmd.div_init = 1'b1;
        // zero time step: derivative is forced to zero, no division needed
        state_next   = stat.dt_zero ? S_DERIV : S_DIV_RUN;
      end
      S_DIV_RUN: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_DERIV;
        end
      end
      S_DERIV: begin
        cmd.deriv_fin = 1'b1;
        state_next    = S_MD_INIT;
      end
      S_MD_INIT: begin
        cmd.mul_init  = 1'b1;
        cmd.mul_sel_d = 1'b1;
        state_next    = S_MD_RUN;
      end
      S_MD_RUN: begin
        cmd.mul_step = 1'b1;
        if (stat.mul_last) begin
          state_next = S_TERM_D;
        end
      end
      S_TERM_D: begin
        cmd.term_d = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/core/pdc_dp.sv
`timescale 1ns / 1ps
// datapath: error, serial restoring divider, digit-serial gain multiplier,
// term sum, clamp, stored error and result register; depends on pdc_pkg
module pdc_dp #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pdc_pkg::pdc_cmd_t            cmd,
  output pdc_pkg::pdc_stat_t           stat,
  input  logic signed [DATA_WIDTH-1:0] prop_gain,
  input  logic signed [DATA_WIDTH-1:0] deriv_gain,
  input  logic signed [DATA_WIDTH-1:0] out_upper,
  input  logic signed [DATA_WIDTH-1:0] out_lower,
  input  logic signed [DATA_WIDTH-1:0] setpoint,
  input  logic signed [DATA_WIDTH-1:0] measured,
  input  logic        [DATA_WIDTH-1:0] step_time,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] drive,
  output logic signed [DATA_WIDTH-1:0] error_now,
  output logic                         clamped
);
  import pdc_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int QW  = W + 1 + F;                  // dividend and quotient bits
  localparam int ND  = (W + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int BW  = ND * DIGIT_BITS;
  localparam int AW  = BW + W;                     // product accumulator
  localparam int XW  = (AW > 64) ? AW : 64;        // term magnitude
  localparam int SW  = XW + 2;                     // sum of two terms
  localparam int MCW = (ND > 1) ? $clog2(ND) : 1;
  localparam int DCW = $clog2(QW);

  localparam logic [W-1:0]  W_MAX    = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  W_MIN    = {1'b1, {(W-1){1'b0}}};
  localparam logic [QW-1:0] LIM_NEG  = QW'(1) << (W - 1);
  localparam logic [QW-1:0] LIM_POS  = (QW'(1) << (W - 1)) - QW'(1);
  localparam logic [XW-1:0] TERM_LIM = XW'(1) << TERM_LIM_BIT;

  // input item
  logic [W-1:0] sp_q;
  logic [W-1:0] ms_q;
  logic [W-1:0] dt_q;

  // error and derivative
  logic [W-1:0] err_q;
  logic [W-1:0] last_error;
  logic [W-1:0] deriv_q;
  logic [W:0]   err_diff;
  logic [W-1:0] err_sat;
  logic [W:0]   d_diff;
  logic [W:0]   d_mag;

  // divider
  logic [W-1:0]   rem;
  logic [QW-1:0]  quo;
  logic           dneg;
  logic [DCW-1:0] dcnt;
  logic [W:0]     rem_sh;
  logic           rem_ge;
  logic [W:0]     rem_sub;
  logic [QW-1:0]  q_lim;
  logic [QW-1:0]  q_sat;

  // multiplier
  logic [W-1:0]            mul_x;
  logic [W-1:0]            mul_g;
  logic [W-1:0]            ma;
  logic [BW-1:0]           mb;
  logic [AW-1:0]           acc;
  logic                    mneg;
  logic [MCW-1:0]          mcnt;
  logic [W+DIGIT_BITS-1:0] pp;

  // terms, sum and clamp
  logic [AW-1:0] prod_sh;
  logic [XW-1:0] tmag;
  logic [XW-1:0] tsat;
  logic [XW:0]   term_n;
  logic [XW:0]   term_p;
  logic [XW:0]   term_d;
  logic [SW-1:0] sum_q;
  logic [SW-1:0] up_ext;
  logic [SW-1:0] lo_ext;
  logic          above;
  logic          below;

  assign stat.dt_zero  = (dt_q == '0);
  assign stat.mul_last = (mcnt == MCW'(ND - 1));
  assign stat.div_last = (dcnt == DCW'(QW - 1));
  assign stat.out_free = !out_valid || out_ready;

  // saturated setpoint - measured
  assign err_diff = {sp_q[W-1], sp_q} - {ms_q[W-1], ms_q};
  assign err_sat  = (err_diff[W] != err_diff[W-1]) ? (err_diff[W] ? W_MIN : W_MAX)
                                                  : err_diff[W-1:0];

  // exact error difference, magnitude never reaches 2^W
  assign d_diff = {err_q[W-1], err_q} - {last_error[W-1], last_error};
  assign d_mag  = d_diff[W] ? -d_diff : d_diff;

  // one restoring step per cycle
  assign rem_sh  = {rem, quo[QW-1]};
  assign rem_ge  = (rem_sh >= {1'b0, dt_q});
  assign rem_sub = rem_sh - {1'b0, dt_q};

  assign q_lim = dneg ? LIM_NEG : LIM_POS;
  assign q_sat = (quo > q_lim) ? q_lim : quo;

  assign mul_x = cmd.mul_sel_d ? deriv_q : err_q;
  assign mul_g = cmd.mul_sel_d ? deriv_gain : prop_gain;
  assign pp    = ma * mb[BW-1 -: DIGIT_BITS];

  // term: shift out fraction bits, saturate magnitude, apply sign
  assign prod_sh = acc >> F;
  assign tmag    = XW'(prod_sh);
  assign tsat    = (tmag > TERM_LIM) ? TERM_LIM : tmag;
  assign term_n  = mneg ? -{1'b0, tsat} : {1'b0, tsat};

  assign up_ext = {{(SW-W){out_upper[W-1]}}, out_upper};
  assign lo_ext = {{(SW-W){out_lower[W-1]}}, out_lower};
  assign above  = $signed(sum_q) > $signed(up_ext);
  assign below  = $signed(sum_q) < $signed(lo_ext);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sp_q <= setpoint;
      ms_q <= measured;
      dt_q <= step_time;
    end
    if (cmd.calc_err) begin
      err_q <= err_sat;
    end
    if (cmd.div_init) begin
      dneg <= d_diff[W];
      quo  <= {d_mag, {F{1'b0}}};
      rem  <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      rem  <= rem_ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
      quo  <= {quo[QW-2:0], rem_ge};
      dcnt <= dcnt + DCW'(1);
    end
    if (cmd.deriv_fin) begin
      if (dt_q == '0) begin
        deriv_q <= '0;
      end else begin
        deriv_q <= dneg ? -q_sat[W-1:0] : q_sat[W-1:0];
      end
    end
    if (cmd.mul_init) begin
      ma   <= mul_x[W-1] ? -mul_x : mul_x;
      mb   <= BW'(mul_g[W-1] ? -mul_g : mul_g);
      mneg <= mul_x[W-1] ^ mul_g[W-1];
      acc  <= '0;
      mcnt <= '0;
    end else if (cmd.mul_step) begin
      // most significant gain digit first
      acc  <= (acc << DIGIT_BITS) + AW'(pp);
      mb   <= mb << DIGIT_BITS;
      mcnt <= mcnt + MCW'(1);
    end
    if (cmd.term_p) begin
      term_p <= term_n;
    end
    if (cmd.term_d) begin
      term_d <= term_n;
    end
    if (cmd.sum) begin
      sum_q <= {term_p[XW], term_p} + {term_d[XW], term_d};
    end
    if (cmd.out_load) begin
      error_now <= err_q;
      clamped   <= above || below;
      if (above) begin
        drive <= out_upper;
      end else if (below) begin
        drive <= out_lower;
      end else begin
        drive <= sum_q[W-1:0];
      end
    end else if (cmd.out_zero) begin
      drive     <= '0;
      error_now <= '0;
      clamped   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        last_error <= err_q;
      end
      if (cmd.out_load || cmd.out_zero) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/pd_controller_clamped.sv
`timescale 1ns / 1ps
// Proportional-derivative controller with clamped output, fixed point with FRAC_BITS
// fraction bits. One result per input item. While enabled, the serial divider for the
// derivative takes most of the time of an item at one quotient bit per cycle, and the
// shared gain multiplier takes a 16-bit digit a cycle. A zero time step skips the
// divider. While disabled an item gives a zero result. A finished result waits in an
// output register, so the next item is taken meanwhile. Register writes are taken in
// any cycle and must happen while idle.
// depends on pdc_pkg, the channel interfaces, pdc_regs, pdc_ctrl and pdc_dp
module pd_controller_clamped #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  pdc_in_if.sink      in_ch,
  pdc_out_if.source   out_ch,
  pdc_cfg_if.sink     cfg
);
  import pdc_pkg::*;

  logic                         enable;
  logic signed [DATA_WIDTH-1:0] prop_gain;
  logic signed [DATA_WIDTH-1:0] deriv_gain;
  logic signed [DATA_WIDTH-1:0] out_upper;
  logic signed [DATA_WIDTH-1:0] out_lower;
  logic                         in_ready;
  pdc_cmd_t                     cmd;
  pdc_stat_t                    stat;

  assign in_ch.ready = in_ready;

  pdc_regs #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_regs (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .enable     (enable),
    .prop_gain  (prop_gain),
    .deriv_gain (deriv_gain),
    .out_upper  (out_upper),
    .out_lower  (out_lower)
  );

  pdc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .enable   (enable),
    .stat     (stat),
    .cmd      (cmd)
  );

  pdc_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .prop_gain  (prop_gain),
    .deriv_gain (deriv_gain),
    .out_upper  (out_upper),
    .out_lower  (out_lower),
    .setpoint   (in_ch.setpoint),
    .measured   (in_ch.measured),
    .step_time  (in_ch.step_time),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .drive      (out_ch.drive),
    .error_now  (out_ch.error_now),
    .clamped    (out_ch.clamped)
  );

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// self-checking bench for pd_controller_clamped: directed table, then random setting phases
// results are checked against the table's typed values or a fixed-point pd predictor kept in this file
// depends on pdc_pkg, the channel interfaces and the controller rtl
module tb;
  import pdc_pkg::*;

  localparam int DW = 32;
  localparam int FB = 16;

  localparam longint W_MAX = (64'sd1 <<< (DW - 1)) - 64'sd1;
  localparam longint W_MIN = -W_MAX - 64'sd1;
  localparam logic [127:0] TERM_CAP = 128'd1 << TERM_LIM_BIT;

  localparam logic [DW-1:0] Z       = '0;
  localparam logic [DW-1:0] ONE     = 32'h0001_0000;
  localparam logic [DW-1:0] NEG_ONE = 32'hFFFF_0000;
  localparam logic [DW-1:0] W_HI    = 32'h7FFF_FFFF;
  localparam logic [DW-1:0] W_LO    = 32'h8000_0000;

  // indexes with no register behind them
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = 3'd7;

  localparam int PLAN_LEN = 38;
  localparam int N_PHASES = 12;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [DW-1:0] drive;
    logic [DW-1:0] error_now;
    logic          clamped;
  } pd_result_t;

  typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_IDX_BITS-1:0] idx;
    logic [DW-1:0]           a;
    logic [DW-1:0]           b;
    logic [DW-1:0]           c;
    logic                    typed;
    logic [DW-1:0]           t_drive;
    logic [DW-1:0]           t_err;
    logic                    t_clamp;
  } plan_row_t;

  logic clk;
  logic rst;

  pdc_in_if  #(.DATA_WIDTH(DW)) in_ch ();
  pdc_out_if #(.DATA_WIDTH(DW)) out_ch ();
  pdc_cfg_if #(.DATA_WIDTH(DW)) cfg ();

  pd_controller_clamped #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  // predictor copy of registers and state
  logic   en_q;
  longint kp_q, kd_q, hi_q, lo_q, last_err_q;

  pd_result_t due_q[$];
  pd_result_t want;

  int n_items, n_zero_dt, n_results, n_clamped, n_writes, n_fail;
  int burst_left;
  bit hold_req, hold_done;
  int hold_left, rx_mode, rx_left;

  plan_row_t plan [PLAN_LEN] = '{
    // disabled after reset: zero result whatever comes in
    '{ROW_ITEM,  '0, W_HI, W_LO, 32'hFFFF_FFFF, 1'b1, Z, Z, 1'b0},
    '{ROW_ITEM,  '0, W_LO, W_HI, Z, 1'b1, Z, Z, 1'b0},
    '{ROW_WRITE, REG_SPARE_A, 32'd1, Z, Z, 1'b0, Z, Z, 1'b0},
    '{ROW_WRITE, REG_SPARE_B, 32'hFFFF_FFFF, Z, Z, 1'b0, Z, Z, 1'b0},
    '{ROW_ITEM,  '0, ONE, Z, ONE, 1'b1, Z, Z, 1'b0},
    '{ROW_WRITE, REG_ENABLE, 32'd1, Z, Z, 1'b0, Z, Z, 1'b0},
    // zero gains: error saturates both ways, drive stays zero
    '{ROW_ITEM,  '0, W_HI, W_LO, Z, 1'b1, Z, W_HI, 1'b0},
    '{ROW_ITEM,  '0, W_LO, W_HI, 32'd1, 1'b1, Z, W_LO, 1'b0},
    '{ROW_WRITE, REG_PROP_GAIN, ONE, Z, Z, 1'b0, Z, Z, 1'b0},
    // unit gain against the reset clamp of +-1.0
    '{ROW_ITEM,  '0, 32'h0003_0000, ONE, ONE, 1'b1, ONE, 32'h0002_0000, 1'b1},
    '{ROW_ITEM,  '0, 32'hFFFD_0000, Z, ONE, 1'b1, NEG_ONE, 32'hFFFD_0000, 1'b1},
    '{ROW_ITEM,  '0, 32'h0000_8000, Z, ONE, 1'b1, 32'h0000_8000, 32'h0000_8000, 1'b0},
    '{ROW_ITEM,  '0, Z, Z, Z, 1'b1, Z, Z, 1'b0},
    '{ROW_WRITE, REG_DERIV_GAIN, ONE, Z, Z, 1'b0, Z, Z, 1'b0},
    '{ROW_WRITE, REG_OUT_UPPER, W_HI, Z, Z, 1'b0, Z, Z, 1'b0},
    '{ROW_WRITE, REG_OUT_LOWER, W_LO, Z, Z, 1'b0, Z, Z, 1'b0},
    // derivative: half step, saturating tiny steps, widest step, zero step
    '{ROW_ITEM,  '0, 32'h0004_0000, Z, 32'h0000_8000, 1'b0, Z, Z, 1'b0},
    '{ROW_ITEM,  '0, Z, 32'h0004_0000, 32'd1, 1'b0, Z, Z, 1'b0},
    '{ROW_ITEM,  '0, W_HI, W_LO, 32'hFFFF_FFFF, 1'b0, Z, Z, 1'b0},
    '{ROW_ITEM,  '0, W_LO, W_HI, 32'd1, 1'b0, Z, Z, 1'b0},
    '{ROW_ITEM,  '0, 32'h1234_5678, Z, Z, 1'b0, Z, Z, 1'b0},
    '{ROW_WRITE, REG_PROP_GAIN, W_HI, Z, Z, 1'b0, Z, Z, 1'b0},
    '{ROW_WRITE, REG_DERIV_GAIN, W_LO, Z, Z, 1'b0, Z, Z, 1'b0},
    '{ROW_ITEM,  '0, W_HI, W_LO, 32'd1, 1'b0, Z, Z, 1'b0},
    '{ROW_ITEM,  '0, W_LO, W_HI, 32'd1, 1'b0, Z, Z, 1'b0},
    '{ROW_ITEM,  '0, Z, 32'd1, ONE, 1'b0, Z, Z, 1'b0},
    '{ROW_WRITE, REG_PROP_GAIN, Z, Z, Z, 1'b0, Z, Z, 1'b0},
    '{ROW_WRITE, REG_DERIV_GAIN, Z, Z, Z, 1'b0, Z, Z, 1'b0},
    '{ROW_WRITE, REG_OUT_UPPER, NEG_ONE, Z, Z, 1'b0, Z, Z, 1'b0},
    '{ROW_WRITE, REG_OUT_LOWER, ONE, Z, Z, 1'b0, Z, Z, 1'b0},
    // crossed limits: upper is checked first and wins
    '{ROW_ITEM,  '0, Z, Z, Z, 1'b1, NEG_ONE, Z, 1'b1},
    '{ROW_WRITE, REG_ENABLE, Z, Z, Z, 1'b0, Z, Z, 1'b0},
    '{ROW_ITEM,  '0, W_HI, Z, 32'd1, 1'b1, Z, Z, 1'b0},
    '{ROW_WRITE, REG_ENABLE, 32'd1, Z, Z, 1'b0, Z, Z, 1'b0},
    '{ROW_WRITE, REG_OUT_UPPER, W_HI, Z, Z, 1'b0, Z, Z, 1'b0},
    '{ROW_WRITE, REG_OUT_LOWER, W_LO, Z, Z, 1'b0, Z, Z, 1'b0},
    '{ROW_WRITE, REG_DERIV_GAIN, ONE, Z, Z, 1'b0, Z, Z, 1'b0},
    // last error must have been held while disabled
    '{ROW_ITEM,  '0, ONE, Z, ONE, 1'b0, Z, Z, 1'b0}
  };

  // (gain * value) >> FB toward zero, magnitude capped
  function automatic longint gain_term(input longint g, input longint v);
    logic [127:0] p;
    u64_t         m;
    logic         neg;
    neg = (g < 0) != (v < 0);
    p = 128'(u64_t'(g < 0 ? -g : g)) * 128'(u64_t'(v < 0 ? -v : v));
    p = p >> FB;
    if (p > TERM_CAP) p = TERM_CAP;
    m = p[63:0];
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // (diff << FB) / dt toward zero, saturated to the data range
  function automatic longint slope(input longint diff, input u64_t dt);
    u64_t n, q, lim;
    logic neg;
    neg = diff < 0;
    n = u64_t'(neg ? -diff : diff);
    lim = neg ? u64_t'(W_MAX) + 1 : u64_t'(W_MAX);
    q = (n << FB) / dt;
    if (q > lim) q = lim;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic pd_result_t control_step(input logic [DW-1:0] sp, ms, dt);
    longint     err, deriv, total, lim_sum;
    logic       clip;
    pd_result_t r;
    r = '0;
    if (!en_q) return r;
    err = longint'(signed'(sp)) - longint'(signed'(ms));
    if (err > W_MAX) err = W_MAX;
    else if (err < W_MIN) err = W_MIN;
    deriv = (dt == 0) ? 0 : slope(err - last_err_q, u64_t'(dt));
    total = gain_term(kp_q, err) + gain_term(kd_q, deriv);
    clip = 1'b1;
    if (total > hi_q) lim_sum = hi_q;
    else if (total < lo_q) lim_sum = lo_q;
    else begin
      lim_sum = total;
      clip = 1'b0;
    end
    last_err_q = err;
    r.drive = lim_sum[DW-1:0];
    r.error_now = err[DW-1:0];
    r.clamped = clip;
    return r;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [DW-1:0] d);
    case (idx)
      REG_ENABLE:     en_q = d[0];
      REG_PROP_GAIN:  kp_q = longint'(signed'(d));
      REG_DERIV_GAIN: kd_q = longint'(signed'(d));
      REG_OUT_UPPER:  hi_q = longint'(signed'(d));
      REG_OUT_LOWER:  lo_q = longint'(signed'(d));
      default: ;
    endcase
  endfunction

  function automatic logic [DW-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return W_HI;
      2: return W_LO;
      3: return Z;
      default: return int'($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
    endcase
  endfunction

  function automatic logic [DW-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0: return W_HI;
      1: return W_LO;
      2: return Z;
      default: return $urandom;
    endcase
  endfunction

  task automatic offer(input logic [DW-1:0] sp, ms, dt, input logic typed,
                       input pd_result_t typed_res);
    pd_result_t r;
    in_ch.valid     <= 1'b1;
    in_ch.setpoint  <= sp;
    in_ch.measured  <= ms;
    in_ch.step_time <= dt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = control_step(sp, ms, dt);
    due_q.push_back(typed ? typed_res : r);
    n_items++;
    if (dt == 0) n_zero_dt++;
    @(negedge clk);
  endtask

  // bursts of random length, random gaps between them
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 10);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 70) : $urandom_range(1, 4);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // stop offering until every result has come back
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (due_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [DW-1:0] d);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= d;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    apply_reg(idx, d);
    n_writes++;
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $error("timeout with %0d results outstanding", due_q.size());
    $display("Some tests failed");
    $finish;
  end

  // receiver: stall modes of random length, plus one long hold-off
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        case (rx_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 1) == 1);
          2: out_ch.ready <= (rx_left % 4 == 0);
          default: out_ch.ready <= ($urandom_range(0, 15) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (out_ch.clamped) n_clamped++;
      if (due_q.size() == 0) begin
        $error("result transfer with nothing outstanding");
        n_fail++;
      end else begin
        want = due_q.pop_front();
        if (out_ch.drive !== want.drive) begin
          $error("drive: expected %0d, actual %0d", $signed(want.drive), $signed(out_ch.drive));
          n_fail++;
        end
        if (out_ch.error_now !== want.error_now) begin
          $error("error_now: expected %0d, actual %0d", $signed(want.error_now),
                 $signed(out_ch.error_now));
          n_fail++;
        end
        if (out_ch.clamped !== want.clamped) begin
          $error("clamped: expected %0d, actual %0d", want.clamped, out_ch.clamped);
          n_fail++;
        end
      end
    end
  end

  initial begin
    pd_result_t    fixed_res;
    logic          cfg_open;
    logic [DW-1:0] sp, ms, dt, hi, lo, d;
    int            sp_base, ms_track, n_ph;

    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.setpoint  <= '0;
    in_ch.measured  <= '0;
    in_ch.step_time <= '0;
    cfg.valid       <= 1'b0;
    cfg.index       <= '0;
    cfg.data        <= '0;
    en_q = 1'b0;
    kp_q = 0;
    kd_q = 0;
    hi_q = longint'(signed'(ONE));
    lo_q = longint'(signed'(NEG_ONE));
    last_err_q = 0;
    cfg_open = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int k = 0; k < PLAN_LEN; k++) begin
      if (plan[k].kind == ROW_WRITE) begin
        if (!cfg_open) settle();
        write_reg(plan[k].idx, plan[k].a);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) begin
          cfg.valid <= 1'b0;
          cfg_open = 1'b0;
        end
        fixed_res.drive = plan[k].t_drive;
        fixed_res.error_now = plan[k].t_err;
        fixed_res.clamped = plan[k].t_clamp;
        offer(plan[k].a, plan[k].b, plan[k].c, plan[k].typed, fixed_res);
        pace();
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      d = $urandom;
      d[0] = (ph != 5);
      write_reg(REG_ENABLE, d);
      write_reg(REG_PROP_GAIN, (ph == 1) ? W_HI : pick_gain());
      write_reg(REG_DERIV_GAIN, (ph == 1) ? W_LO : pick_gain());
      case ((ph < 3) ? ph : $urandom_range(0, 3))
        0: begin
          hi = $urandom_range(0, 32'h8_0000);
          lo = -$urandom_range(0, 32'h8_0000);
        end
        1: begin
          hi = W_HI;
          lo = W_LO;
        end
        2: begin
          // crossed extremes
          hi = W_LO;
          lo = W_HI;
        end
        default: begin
          hi = $urandom;
          lo = $urandom;
        end
      endcase
      write_reg(REG_OUT_UPPER, hi);
      write_reg(REG_OUT_LOWER, lo);
      if (ph % 4 == 3) write_reg(REG_SPARE_A, $urandom);
      cfg.valid <= 1'b0;
      if (ph == 3) hold_req = 1'b1;

      sp_base = int'($urandom_range(0, 32'h20_0000)) - 32'sh10_0000;
      ms_track = int'($urandom_range(0, 32'h20_0000)) - 32'sh10_0000;
      n_ph = (ph == 5) ? 40 : 100;
      for (int i = 0; i < n_ph; i++) begin
        // mostly well-formed: measurement settling toward a setpoint that jumps now and then
        if ($urandom_range(0, 19) == 0)
          sp_base = int'($urandom_range(0, 32'h20_0000)) - 32'sh10_0000;
        ms_track = ms_track + ((sp_base - ms_track) >>> 3)
                   + (int'($urandom_range(0, 32'h8000)) - 32'sh4000);
        sp = sp_base;
        ms = ms_track;
        dt = $urandom_range(32'h100, 32'h2_0000);
        case ($urandom_range(0, 9))
          6: begin
            sp = $urandom;
            ms = $urandom;
            dt = $urandom;
          end
          7: begin
            sp = pick_extreme();
            ms = pick_extreme();
            dt = $urandom_range(1, 32'h1_0000);
          end
          8: begin
            case ($urandom_range(0, 2))
              0: dt = Z;
              1: dt = 32'd1;
              default: dt = 32'hFFFF_FFFF;
            endcase
          end
          9: dt = $urandom;
          default: ;
        endcase
        offer(sp, ms, dt, 1'b0, '0);
        pace();
      end
    end

    settle();
    repeat (100) @(posedge clk);
    $display("run covered %0d items (%0d with zero time step), %0d results, %0d clamped",
             n_items, n_zero_dt, n_results, n_clamped);
    $display("%0d register writes over the directed table and %0d random settings, %0d mismatches",
             n_writes, N_PHASES, n_fail);
    if (n_fail == 0 && due_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
